@@ design/sbc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package sbc_pkg;

  localparam int unsigned ENTRY_COUNT_DEF = 16;
  localparam logic [31:0] BUDGET_RESET    = 32'd1048576;

  // Operation classes after decode
  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_LOOKUP = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  // Back-end sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_KSCAN,
    ST_REMOVE,
    ST_EXPIRE,
    ST_WRITE,
    ST_BUDGET,
    ST_EVSCAN,
    ST_EVREAD,
    ST_EVDROP,
    ST_CLEAR,
    ST_DONE
  } state_e;

  // Command passed from front to back
  typedef struct packed {
    op_e         op;
    logic [47:0] key;
    logic [15:0] value;
    logic [31:0] size;
    logic [31:0] ttl;
    logic [47:0] stamp;
    logic [47:0] now;
  } cmd_t;

  // Stored entry payload
  typedef struct packed {
    logic [47:0] key;
    logic [15:0] value;
    logic [31:0] size;
    logic [31:0] ttl;
    logic [47:0] stamp;
  } entry_t;

  // Result item
  typedef struct packed {
    logic        hit;
    logic        expired;
    logic [15:0] value;
    logic [31:0] size;
    logic [31:0] ttl;
    logic [47:0] stamp;
    logic [31:0] bytes_held;
    logic [4:0]  evicted;
  } result_t;

endpackage
`default_nettype wire

@@ design/sbc_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
module sbc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // one write port, registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

@@ design/sbc_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
module sbc_front (
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  input  wire logic [1:0]     operation_i,
  input  wire logic [47:0]    key_tag_i,
  input  wire logic [15:0]    value_handle_i,
  input  wire logic [31:0]    entry_size_i,
  input  wire logic [31:0]    time_to_live_i,
  input  wire logic [47:0]    insert_time_i,
  input  wire logic [47:0]    now_time_i,
  output logic                push_o,
  input  wire logic           push_ready_i,
  output sbc_pkg::cmd_t       cmd_o
);

  sbc_pkg::op_e op_cls;

  // classify the operation code
  always_comb begin
    case (operation_i)
      sbc_pkg::OP_INSERT: op_cls = sbc_pkg::OP_INSERT;
      sbc_pkg::OP_LOOKUP: op_cls = sbc_pkg::OP_LOOKUP;
      sbc_pkg::OP_CLEAR:  op_cls = sbc_pkg::OP_CLEAR;
      default:            op_cls = sbc_pkg::OP_NONE;
    endcase
  end

  // transfer straight into the queue when it has room
  assign in_ready_o = push_ready_i;
  assign push_o     = in_valid_i & push_ready_i;

  always_comb begin
    cmd_o.op    = op_cls;
    cmd_o.key   = key_tag_i;
    cmd_o.value = value_handle_i;
    cmd_o.size  = entry_size_i;
    cmd_o.ttl   = time_to_live_i;
    cmd_o.stamp = insert_time_i;
    cmd_o.now   = now_time_i;
  end

endmodule
`default_nettype wire

@@ design/sbc_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none
module sbc_queue (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     push_i,
  output logic          push_ready_o,
  input  sbc_pkg::cmd_t push_data_i,
  output logic          pop_valid_o,
  input  wire logic     pop_i,
  output sbc_pkg::cmd_t pop_data_o
);

  sbc_pkg::cmd_t mem_q [2];
  logic          wptr_q, rptr_q;
  logic [1:0]    cnt_q;

  assign push_ready_o = (cnt_q != 2'd2);
  assign pop_valid_o  = (cnt_q != 2'd0);
  assign pop_data_o   = mem_q[rptr_q];

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= push_data_i;
    end
  end

  // pointers and fill
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (push_i) wptr_q <= ~wptr_q;
      if (pop_i)  rptr_q <= ~rptr_q;
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule
`default_nettype wire

@@ design/sbc_engine.sv @@
`timescale 1ns / 1ps
`default_nettype none
module sbc_engine #(
  parameter int unsigned ENTRY_COUNT = sbc_pkg::ENTRY_COUNT_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic [31:0] budget_i,
  input  wire logic        cmd_valid_i,
  output logic             cmd_pop_o,
  input  sbc_pkg::cmd_t    cmd_i,
  output logic             res_valid_o,
  input  wire logic        res_ready_i,
  output sbc_pkg::result_t res_o
);

  localparam int unsigned IW = $clog2(ENTRY_COUNT);
  localparam int unsigned CW = $clog2(ENTRY_COUNT + 1);
  localparam int unsigned EW = $bits(sbc_pkg::entry_t);

  sbc_pkg::state_e  state_q, state_d;
  sbc_pkg::cmd_t    cmd_q;
  sbc_pkg::entry_t  hold_q, rdata, wdata;
  sbc_pkg::result_t out_q;
  logic             out_valid_q;

  logic [CW-1:0] ctr_q, count_q, evicted_q;
  logic          pend_q, free_ok_q, ret_write_q, hit_q, exp_q;
  logic [IW-1:0] pidx_q, free_q, slot_q;
  logic          valid_q [ENTRY_COUNT];
  logic [IW-1:0] rank_q  [ENTRY_COUNT];
  logic [32:0]   total_q;

  // sequencer actions
  logic          do_remove, do_write, do_clear, do_load;
  logic [IW-1:0] raddr, rem_rank;
  logic [31:0]   rem_bytes;
  logic          match, scan_done, ev_hit, expired;
  logic [47:0]   age;
  logic [IW-1:0] ctr_idx;

  assign ctr_idx  = ctr_q[IW-1:0];
  assign rem_rank = rank_q[slot_q];

  assign wdata.key   = cmd_q.key;
  assign wdata.value = cmd_q.value;
  assign wdata.size  = cmd_q.size;
  assign wdata.ttl   = cmd_q.ttl;
  assign wdata.stamp = cmd_q.stamp;

  logic [EW-1:0] rdata_raw;
  assign rdata = sbc_pkg::entry_t'(rdata_raw);

  sbc_ram #(
    .WIDTH (EW),
    .DEPTH (ENTRY_COUNT)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (do_write),
    .waddr_i (slot_q),
    .wdata_i (EW'(wdata)),
    .raddr_i (raddr),
    .rdata_o (rdata_raw)
  );

  // key compare on returned read data, oldest search over flop ranks
  assign match     = pend_q && valid_q[pidx_q] && (rdata.key == cmd_q.key);
  assign scan_done = (ctr_q == CW'(ENTRY_COUNT)) && !pend_q;
  assign ev_hit    = valid_q[ctr_idx] && (rank_q[ctr_idx] == IW'(count_q - CW'(1)));
  assign age       = (cmd_q.now >= hold_q.stamp) ? (cmd_q.now - hold_q.stamp) : 48'd0;
  assign expired   = (age >= {16'd0, hold_q.ttl});

  // next state and actions
  always_comb begin
    state_d   = state_q;
    cmd_pop_o = 1'b0;
    do_remove = 1'b0;
    do_write  = 1'b0;
    do_clear  = 1'b0;
    do_load   = 1'b0;
    raddr     = slot_q;
    rem_bytes = hold_q.size;
    case (state_q)
      sbc_pkg::ST_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          case (cmd_i.op)
            sbc_pkg::OP_INSERT, sbc_pkg::OP_LOOKUP: state_d = sbc_pkg::ST_KSCAN;
            sbc_pkg::OP_CLEAR:                      state_d = sbc_pkg::ST_CLEAR;
            default:                                state_d = sbc_pkg::ST_DONE;
          endcase
        end
      end
      sbc_pkg::ST_KSCAN: begin
        raddr = ctr_idx;
        if (match) begin
          state_d = (cmd_q.op == sbc_pkg::OP_INSERT) ? sbc_pkg::ST_REMOVE
                                                     : sbc_pkg::ST_EXPIRE;
        end else if (scan_done) begin
          if (cmd_q.op != sbc_pkg::OP_INSERT) begin
            state_d = sbc_pkg::ST_DONE;
          end else if (count_q == CW'(ENTRY_COUNT)) begin
            state_d = sbc_pkg::ST_EVSCAN;
          end else begin
            state_d = sbc_pkg::ST_WRITE;
          end
        end
      end
      sbc_pkg::ST_REMOVE: begin
        do_remove = 1'b1;
        state_d   = sbc_pkg::ST_WRITE;
      end
      sbc_pkg::ST_EXPIRE: begin
        do_remove = expired;
        state_d   = sbc_pkg::ST_DONE;
      end
      sbc_pkg::ST_WRITE: begin
        do_write = 1'b1;
        state_d  = sbc_pkg::ST_BUDGET;
      end
      sbc_pkg::ST_BUDGET: begin
        if ((total_q > {1'b0, budget_i}) && (count_q != '0)) begin
          state_d = sbc_pkg::ST_EVSCAN;
        end else begin
          state_d = sbc_pkg::ST_DONE;
        end
      end
      sbc_pkg::ST_EVSCAN: begin
        if (ev_hit) state_d = sbc_pkg::ST_EVREAD;
      end
      sbc_pkg::ST_EVREAD: begin
        state_d = sbc_pkg::ST_EVDROP;
      end
      sbc_pkg::ST_EVDROP: begin
        do_remove = 1'b1;
        rem_bytes = rdata.size;
        state_d   = ret_write_q ? sbc_pkg::ST_WRITE : sbc_pkg::ST_BUDGET;
      end
      sbc_pkg::ST_CLEAR: begin
        do_clear = 1'b1;
        state_d  = sbc_pkg::ST_DONE;
      end
      sbc_pkg::ST_DONE: begin
        if (!out_valid_q || res_ready_i) begin
          do_load = 1'b1;
          state_d = sbc_pkg::ST_IDLE;
        end
      end
      default: state_d = sbc_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sbc_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // per-operation working registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      sbc_pkg::ST_IDLE: begin
        cmd_q       <= cmd_i;
        ctr_q       <= '0;
        pend_q      <= 1'b0;
        free_ok_q   <= 1'b0;
        hit_q       <= 1'b0;
        exp_q       <= 1'b0;
        evicted_q   <= '0;
        ret_write_q <= 1'b0;
      end
      sbc_pkg::ST_KSCAN: begin
        pend_q <= 1'b0;
        if (ctr_q != CW'(ENTRY_COUNT)) begin
          pend_q <= 1'b1;
          pidx_q <= ctr_idx;
          ctr_q  <= ctr_q + CW'(1);
          if (!free_ok_q && !valid_q[ctr_idx]) begin
            free_q    <= ctr_idx;
            free_ok_q <= 1'b1;
          end
        end
        if (match) begin
          slot_q <= pidx_q;
          hold_q <= rdata;
        end else if (scan_done) begin
          slot_q      <= free_q;
          ctr_q       <= '0;
          ret_write_q <= 1'b1;
        end
      end
      sbc_pkg::ST_EXPIRE: begin
        hit_q <= !expired;
        exp_q <= expired;
      end
      sbc_pkg::ST_WRITE: begin
        ret_write_q <= 1'b0;
      end
      sbc_pkg::ST_BUDGET: begin
        ctr_q <= '0;
      end
      sbc_pkg::ST_EVSCAN: begin
        if (ev_hit) begin
          slot_q <= ctr_idx;
        end else begin
          ctr_q <= ctr_q + CW'(1);
        end
      end
      sbc_pkg::ST_EVDROP: begin
        evicted_q <= evicted_q + CW'(1);
      end
      default: ;
    endcase
  end

  // entry valid bits, live count and byte total
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < ENTRY_COUNT; i++) valid_q[i] <= 1'b0;
      count_q <= '0;
      total_q <= '0;
    end else if (do_clear) begin
      for (int i = 0; i < ENTRY_COUNT; i++) valid_q[i] <= 1'b0;
      count_q <= '0;
      total_q <= '0;
    end else if (do_remove) begin
      valid_q[slot_q] <= 1'b0;
      count_q <= count_q - CW'(1);
      total_q <= total_q - {1'b0, rem_bytes};
    end else if (do_write) begin
      valid_q[slot_q] <= 1'b1;
      count_q <= count_q + CW'(1);
      total_q <= total_q + {1'b0, cmd_q.size};
    end
  end

  // age ranks: close the gap on removal, age everyone on insert
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < ENTRY_COUNT; i++) begin
      if (do_remove) begin
        if (valid_q[i] && (rank_q[i] > rem_rank)) rank_q[i] <= rank_q[i] - IW'(1);
      end else if (do_write) begin
        if (IW'(i) == slot_q) begin
          rank_q[i] <= '0;
        end else if (valid_q[i]) begin
          rank_q[i] <= rank_q[i] + IW'(1);
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (do_load) begin
      out_valid_q <= 1'b1;
    end else if (res_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_load) begin
      out_q.hit        <= hit_q;
      out_q.expired    <= exp_q;
      out_q.value      <= hit_q ? hold_q.value : 16'd0;
      out_q.size       <= hit_q ? hold_q.size  : 32'd0;
      out_q.ttl        <= hit_q ? hold_q.ttl   : 32'd0;
      out_q.stamp      <= hit_q ? hold_q.stamp : 48'd0;
      out_q.bytes_held <= total_q[31:0];
      out_q.evicted    <= 5'(evicted_q);
    end
  end

  assign res_valid_o = out_valid_q;
  assign res_o       = out_q;

endmodule
`default_nettype wire

@@ design/size_budget_cache_with_ttl.sv @@
// Throughput: one item at a time; the key scan reads one entry per cycle from the
// entry RAM and each eviction scans age ranks one slot per cycle.
// Reset: table empty, byte total zero, size budget 1048576; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
module size_budget_cache_with_ttl #(
  parameter int unsigned ENTRY_COUNT = sbc_pkg::ENTRY_COUNT_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [31:0] cfg_wdata_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  operation_i,
  input  wire logic [47:0] key_tag_i,
  input  wire logic [15:0] value_handle_i,
  input  wire logic [31:0] entry_size_i,
  input  wire logic [31:0] time_to_live_i,
  input  wire logic [47:0] insert_time_i,
  input  wire logic [47:0] now_time_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic             hit_o,
  output logic             expired_removed_o,
  output logic [15:0]      found_value_o,
  output logic [31:0]      found_size_o,
  output logic [31:0]      found_ttl_o,
  output logic [47:0]      found_insert_time_o,
  output logic [31:0]      bytes_held_o,
  output logic [4:0]       evicted_count_o
);

  logic [31:0]      budget_q;
  logic             push, push_ready, pop_valid, pop;
  sbc_pkg::cmd_t    push_cmd, pop_cmd;
  sbc_pkg::result_t res;

  // size budget register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      budget_q <= sbc_pkg::BUDGET_RESET;
    end else if (cfg_we_i) begin
      budget_q <= cfg_wdata_i;
    end
  end

  sbc_front u_front (
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .operation_i    (operation_i),
    .key_tag_i      (key_tag_i),
    .value_handle_i (value_handle_i),
    .entry_size_i   (entry_size_i),
    .time_to_live_i (time_to_live_i),
    .insert_time_i  (insert_time_i),
    .now_time_i     (now_time_i),
    .push_o         (push),
    .push_ready_i   (push_ready),
    .cmd_o          (push_cmd)
  );

  sbc_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_ready_o (push_ready),
    .push_data_i  (push_cmd),
    .pop_valid_o  (pop_valid),
    .pop_i        (pop),
    .pop_data_o   (pop_cmd)
  );

  sbc_engine #(
    .ENTRY_COUNT (ENTRY_COUNT)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .budget_i    (budget_q),
    .cmd_valid_i (pop_valid),
    .cmd_pop_o   (pop),
    .cmd_i       (pop_cmd),
    .res_valid_o (out_valid_o),
    .res_ready_i (out_ready_i),
    .res_o       (res)
  );

  assign hit_o               = res.hit;
  assign expired_removed_o   = res.expired;
  assign found_value_o       = res.value;
  assign found_size_o        = res.size;
  assign found_ttl_o         = res.ttl;
  assign found_insert_time_o = res.stamp;
  assign bytes_held_o        = res.bytes_held;
  assign evicted_count_o     = res.evicted;

endmodule
`default_nettype wire

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps
module tb_top;
  import sbc_pkg::*;

  localparam int NENT       = 16;
  localparam int STALL_LIMIT = 20000;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [31:0] cfg_wdata_i;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [1:0]  operation_i;
  logic [47:0] key_tag_i;
  logic [15:0] value_handle_i;
  logic [31:0] entry_size_i;
  logic [31:0] time_to_live_i;
  logic [47:0] insert_time_i;
  logic [47:0] now_time_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic        hit_o;
  logic        expired_removed_o;
  logic [15:0] found_value_o;
  logic [31:0] found_size_o;
  logic [31:0] found_ttl_o;
  logic [47:0] found_insert_time_o;
  logic [31:0] bytes_held_o;
  logic [4:0]  evicted_count_o;

  size_budget_cache_with_ttl i_dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i, .in_valid_i, .in_ready_o,
    .operation_i, .key_tag_i, .value_handle_i, .entry_size_i, .time_to_live_i,
    .insert_time_i, .now_time_i, .out_valid_o, .out_ready_i, .hit_o,
    .expired_removed_o, .found_value_o, .found_size_o, .found_ttl_o,
    .found_insert_time_o, .bytes_held_o, .evicted_count_o
  );

  // Shadow copy of the cache table
  logic        sh_valid [NENT];
  logic [47:0] sh_key   [NENT];
  logic [15:0] sh_value [NENT];
  logic [31:0] sh_bytes [NENT];
  logic [31:0] sh_ttl   [NENT];
  logic [47:0] sh_stamp [NENT];
  int          sh_rank  [NENT];
  logic [63:0] sh_total;
  logic [31:0] sh_budget;

  result_t     pending_results[$];
  int          n_err, n_checked, n_sent, n_hits, n_expired, n_evicting;
  int          idle_pct, stall_pct, quiet_cycles;
  logic [47:0] key_pool[24];

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic logic [47:0] rand48();
    return 48'({$urandom, $urandom});
  endfunction

  function automatic int live_count();
    int n;
    n = 0;
    for (int i = 0; i < NENT; i++) if (sh_valid[i]) n++;
    return n;
  endfunction

  function automatic int slot_of(logic [47:0] key);
    for (int i = 0; i < NENT; i++) if (sh_valid[i] && sh_key[i] == key) return i;
    return -1;
  endfunction

  function automatic void drop_slot(int s);
    for (int i = 0; i < NENT; i++)
      if (sh_valid[i] && sh_rank[i] > sh_rank[s]) sh_rank[i]--;
    sh_valid[s] = 1'b0;
    sh_total    = sh_total - sh_bytes[s];
  endfunction

  function automatic int drop_oldest();
    int n;
    n = live_count();
    if (n == 0) return 0;
    for (int i = 0; i < NENT; i++)
      if (sh_valid[i] && sh_rank[i] == n - 1) begin
        drop_slot(i);
        return 1;
      end
    return 0;
  endfunction

  // Work out the result of one accepted item and update the shadow table
  function automatic result_t cache_outcome(logic [1:0] op, logic [47:0] key,
      logic [15:0] val, logic [31:0] size, logic [31:0] ttl, logic [47:0] stamp,
      logic [47:0] now);
    result_t r;
    int s, f, ev;
    logic [47:0] age;
    r  = '0;
    ev = 0;
    case (op_e'(op))
      OP_INSERT: begin
        s = slot_of(key);
        if (s >= 0) drop_slot(s);
        else if (live_count() >= NENT) ev += drop_oldest();
        f = -1;
        for (int i = 0; i < NENT; i++) begin
          if (sh_valid[i]) sh_rank[i]++;
          else if (f < 0) f = i;
        end
        if (f >= 0) begin
          sh_valid[f] = 1'b1;
          sh_key[f]   = key;
          sh_value[f] = val;
          sh_bytes[f] = size;
          sh_ttl[f]   = ttl;
          sh_stamp[f] = stamp;
          sh_rank[f]  = 0;
          sh_total    = sh_total + size;
        end
        while (sh_total > {32'd0, sh_budget} && live_count() > 0) ev += drop_oldest();
      end
      OP_LOOKUP: begin
        s = slot_of(key);
        if (s >= 0) begin
          age = (now >= sh_stamp[s]) ? now - sh_stamp[s] : '0;
          if (age >= {16'd0, sh_ttl[s]}) begin
            drop_slot(s);
            r.expired = 1'b1;
          end else begin
            r.hit   = 1'b1;
            r.value = sh_value[s];
            r.size  = sh_bytes[s];
            r.ttl   = sh_ttl[s];
            r.stamp = sh_stamp[s];
          end
        end
      end
      OP_CLEAR: begin
        for (int i = 0; i < NENT; i++) sh_valid[i] = 1'b0;
        sh_total = '0;
      end
      default: ;
    endcase
    r.bytes_held = sh_total[31:0];
    r.evicted    = ev[4:0];
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    n_err++;
    $display("%0t mismatch on %s: got 0x%0h, want 0x%0h", $realtime, what, got, want);
  endtask

  // Predict at each input transfer
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) begin
      pending_results.push_back(cache_outcome(operation_i, key_tag_i, value_handle_i,
          entry_size_i, time_to_live_i, insert_time_i, now_time_i));
      n_sent++;
    end
  end

  // Check each output transfer against the oldest prediction
  always @(posedge clk_i) begin
    result_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        n_err++;
        $display("%0t result with nothing pending", $realtime);
      end else begin
        e = pending_results.pop_front();
        n_checked++;
        if (e.hit) n_hits++;
        if (e.expired) n_expired++;
        if (e.evicted != 0) n_evicting++;
        if (hit_o !== e.hit) report_mismatch("hit", hit_o, e.hit);
        if (expired_removed_o !== e.expired)
          report_mismatch("expired_removed", expired_removed_o, e.expired);
        if (found_value_o !== e.value) report_mismatch("found_value", found_value_o, e.value);
        if (found_size_o !== e.size) report_mismatch("found_size", found_size_o, e.size);
        if (found_ttl_o !== e.ttl) report_mismatch("found_ttl", found_ttl_o, e.ttl);
        if (found_insert_time_o !== e.stamp)
          report_mismatch("found_insert_time", found_insert_time_o, e.stamp);
        if (bytes_held_o !== e.bytes_held)
          report_mismatch("bytes_held", bytes_held_o, e.bytes_held);
        if (evicted_count_o !== e.evicted)
          report_mismatch("evicted_count", evicted_count_o, e.evicted);
      end
    end
  end

  // Receiver back-pressure
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= stall_pct);
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("timeout with %0d results pending", pending_results.size());
      $display("tb_top failed");
      $finish;
    end
  end

  // Called at a clock edge; valid stays high into the next item when no idle is drawn
  task automatic send_item(logic [1:0] op, logic [47:0] key, logic [15:0] val,
      logic [31:0] size, logic [31:0] ttl, logic [47:0] stamp, logic [47:0] now);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    operation_i    <= op;
    key_tag_i      <= key;
    value_handle_i <= val;
    entry_size_i   <= size;
    time_to_live_i <= ttl;
    insert_time_i  <= stamp;
    now_time_i     <= now;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_budget(logic [31:0] b);
    drain();
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= b;
    @(posedge clk_i);
    cfg_we_i  <= 1'b0;
    sh_budget = b;
  endtask

  // Field extremes, every operation, and the corner cases
  task automatic test_directed();
    logic [47:0] ones48;
    ones48 = '1;
    send_item(OP_INSERT, '0, '0, '0, '1, '0, '0);
    send_item(OP_INSERT, ones48, 16'hffff, 32'd4096, 32'hffff_ffff, ones48, ones48);
    send_item(OP_LOOKUP, '0, '0, '0, '0, '0, ones48);
    send_item(OP_LOOKUP, ones48, '0, '0, '0, '0, '0);       // clock behind stamp
    send_item(OP_LOOKUP, 48'h1234, '0, '0, '0, '0, '0);     // miss
    send_item(OP_INSERT, 48'h77, 16'h5a5a, 32'd100, 32'd0, 48'd50, '0);
    send_item(OP_LOOKUP, 48'h77, '0, '0, '0, '0, 48'd50);   // zero lifetime
    send_item(OP_INSERT, ones48, 16'h0001, 32'd8, 32'd9, 48'd3, '0); // replace key
    send_item(OP_LOOKUP, ones48, '0, '0, '0, '0, 48'd11);
    send_item(OP_LOOKUP, ones48, '0, '0, '0, '0, 48'd12);   // age equals lifetime
    send_item(OP_INSERT, 48'h99, 16'h1, 32'hffff_ffff, 32'd5, '0, '0); // over budget
    send_item(OP_NONE, ones48, '1, '1, '1, '1, '1);          // unused code
    for (int i = 0; i < 17; i++)                             // table full by count
      send_item(OP_INSERT, 48'h100 + i, i[15:0], 32'd16, 32'd1000, 48'd0, '0);
    send_item(OP_CLEAR, '0, '0, '0, '0, '0, '0);
    drain();
    // Lowered budget applies only at the next insert
    for (int i = 0; i < 4; i++)
      send_item(OP_INSERT, 48'h200 + i, '0, 32'd100, 32'd50, '0, '0);
    write_budget(32'd150);
    send_item(OP_LOOKUP, 48'h200, '0, '0, '0, '0, 48'd1);
    send_item(OP_INSERT, 48'h300, '0, 32'd10, 32'd50, '0, '0);
  endtask

  // Random traffic over a small key pool so hits and replacements are common
  task automatic test_random(int items, logic [31:0] budget, int size_max);
    logic [47:0] key, stamp, now;
    int pick;
    write_budget(budget);
    for (int i = 0; i < 24; i++)
      key_pool[i] = (i < 4) ? rand48() : 48'(i * 5);
    for (int i = 0; i < items; i++) begin
      if (i == items / 2) drain();
      pick  = $urandom_range(99);
      key   = key_pool[$urandom_range(23)];
      stamp = ($urandom_range(9) == 0) ? rand48() : 48'($urandom_range(1000));
      now   = ($urandom_range(9) == 0) ? rand48() : 48'($urandom_range(1200));
      if (pick < 48)
        send_item(OP_INSERT, key, 16'($urandom),
                  ($urandom_range(15) == 0) ? $urandom : $urandom_range(size_max),
                  ($urandom_range(15) == 0) ? $urandom : $urandom_range(400),
                  stamp, rand48());
      else if (pick < 95)
        send_item(OP_LOOKUP, key, 16'($urandom), $urandom, $urandom, rand48(), now);
      else if (pick < 98)
        send_item(OP_CLEAR, rand48(), 16'($urandom), $urandom, $urandom, rand48(),
                  rand48());
      else
        send_item(OP_NONE, rand48(), 16'($urandom), $urandom, $urandom, rand48(),
                  rand48());
    end
  endtask

  initial begin
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = '0;
    in_valid_i  = 1'b0;
    operation_i = '0;
    key_tag_i   = '0;
    value_handle_i = '0;
    entry_size_i   = '0;
    time_to_live_i = '0;
    insert_time_i  = '0;
    now_time_i     = '0;
    out_ready_i    = 1'b1;
    idle_pct = 0;
    stall_pct = 0;
    quiet_cycles = 0;
    n_err = 0; n_checked = 0; n_sent = 0; n_hits = 0; n_expired = 0; n_evicting = 0;
    for (int i = 0; i < NENT; i++) begin
      sh_valid[i] = 1'b0;
      sh_rank[i]  = 0;
    end
    sh_total  = '0;
    sh_budget = BUDGET_RESET;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_directed();
    idle_pct = 0;  stall_pct = 0;  test_random(330, 32'd1000, 300);
    idle_pct = 51; stall_pct = 0;  test_random(330, 32'hffff_ffff, 100000);
    idle_pct = 0;  stall_pct = 51; test_random(330, 32'd0, 3);
    idle_pct = 6;  stall_pct = 6;  test_random(330, BUDGET_RESET, 200000);

    drain();
    repeat (400) @(posedge clk_i);
    $display("Ran %0d items, %0d results checked: %0d hits, %0d expiries, %0d evicting inserts",
             n_sent, n_checked, n_hits, n_expired, n_evicting);
    $display("Budgets swept from zero to all ones under four idle and stall mixes");
    if (n_err == 0 && pending_results.size() == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
